### rtl/core/mccr_pkg.sv
// ----------------------------------------------------------------------------
// mccr_pkg: shared constants for the memory card command responder
// Function codes, command codes, reply codes and the fixed reply tables.
// ----------------------------------------------------------------------------
package mccr_pkg;

  localparam int FLASH_BLOCKS_DEF = 256;
  localparam int BLOCK_BYTES_DEF  = 512;
  localparam int LCD_BYTES        = 192;
  localparam int LCD_WORDS        = LCD_BYTES / 4;
  localparam int LCD_AW           = $clog2(LCD_WORDS);

  localparam logic [31:0] FN_STORAGE = 32'h0200_0000;
  localparam logic [31:0] FN_LCD     = 32'h0400_0000;
  localparam logic [31:0] FN_CLOCK   = 32'h0800_0000;

  localparam logic [7:0] CMD_IDENT = 8'h01;
  localparam logic [7:0] CMD_INFO  = 8'h0A;
  localparam logic [7:0] CMD_READ  = 8'h0B;
  localparam logic [7:0] CMD_WRITE = 8'h0C;
  localparam logic [7:0] CMD_SYNC  = 8'h0D;
  localparam logic [7:0] CMD_SET   = 8'h0E;

  localparam logic [2:0] RC_STATUS  = 3'd0;
  localparam logic [2:0] RC_OK      = 3'd1;
  localparam logic [2:0] RC_DATA    = 3'd2;
  localparam logic [2:0] RC_BAD_FN  = 3'd3;
  localparam logic [2:0] RC_BAD_CMD = 3'd4;
  localparam logic [2:0] RC_RESEND  = 3'd5;

  localparam logic [0:0] CFG_DATE = 1'b0;
  localparam logic [0:0] CFG_TIME = 1'b1;

  localparam logic [31:0] LCD_INFO_WORD = 32'h0010_1f2f;

  // Identity reply, 28 words, bytes little endian within each word.
  function automatic logic [31:0] ident_word(input logic [7:0] idx);
    logic [31:0] w;
    case (idx)
      8'd0:  w = 32'h0e00_0000;
      8'd1:  w = 32'h403f_7e7e;
      8'd2:  w = 32'h0010_0500;
      8'd3:  w = 32'h0041_0f00;
      8'd4:  w = 32'h6956_00ff;
      8'd5:  w = 32'h6c61_7573;
      8'd6:  w = 32'h6d65_4d20;
      8'd7:  w = 32'h2079_726f;
      8'd8, 8'd9, 8'd10, 8'd11, 8'd26: w = 32'h2020_2020;
      8'd12: w = 32'h646f_7250;
      8'd13: w = 32'h6465_6375;
      8'd14: w = 32'h2079_4220;
      8'd15: w = 32'h5520_726f;
      8'd16: w = 32'h7265_646e;
      8'd17: w = 32'h6369_4c20;
      8'd18: w = 32'h6573_6e65;
      8'd19: w = 32'h6f72_4620;
      8'd20: w = 32'h4553_206d;
      8'd21: w = 32'h4520_4147;
      8'd22: w = 32'h5245_544e;
      8'd23: w = 32'h5349_5250;
      8'd24: w = 32'h4c2c_5345;
      8'd25: w = 32'h202e_4454;
      8'd27: w = 32'h0082_007c;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  // Storage media info reply, 7 words.
  function automatic logic [31:0] info_word(input logic [7:0] idx);
    logic [31:0] w;
    case (idx)
      8'd0: w = FN_STORAGE;
      8'd1: w = 32'h0000_00ff;
      8'd2: w = 32'h00fe_00ff;
      8'd3: w = 32'h00fd_0001;
      8'd4: w = 32'h0000_000d;
      8'd5: w = 32'h001f_00c8;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

### rtl/core/memory_card_command_responder.sv
// Path: an accepted beat passes through the result stage, then the output register.
// The block takes no new input beat while one is in the result stage or the output register;
// in_ready stays low until the output beat has been taken.
// Reset: synchronous, active low. After reset the block sweeps the flash store to zero,
// one word a cycle over all FLASH_BLOCKS*BLOCK_BYTES/4 words (32768 by default), with in_ready low.
// ----------------------------------------------------------------------------
// memory_card_command_responder
// Serial-bus memory card responder: request frames in, reply words out.
// ----------------------------------------------------------------------------
module memory_card_command_responder import mccr_pkg::*; #(
  parameter int FLASH_BLOCKS = FLASH_BLOCKS_DEF,
  parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic        in_frame_start,
  input  logic [7:0]  in_command,
  input  logic [31:0] in_data,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_reply_word,
  output logic        out_word_valid,
  output logic        out_reply_last,
  output logic [2:0]  out_reply_code,
  output logic        out_code_valid,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int BW    = BLOCK_BYTES / 4;
  localparam int PH    = BLOCK_BYTES / 16;
  localparam int FW    = FLASH_BLOCKS * BW;
  localparam int AW    = $clog2(FW);
  localparam int STW   = 16 + $clog2(BW + 1) + 1;
  localparam int RECIP = (65536 + FLASH_BLOCKS - 1) / FLASH_BLOCKS;

  typedef enum logic [2:0] {
    K_NONE, K_IDENT, K_INFO_ST, K_INFO_LCD, K_READ_ST, K_READ_LCD, K_READ_CLK
  } kind_t;

  typedef enum logic [1:0] {SRC_CONST, SRC_FLASH, SRC_LCD} src_t;

  // Memories: the flash and LCD stores.
  logic [31:0] flash_mem [FW];
  logic [31:0] lcd_mem [LCD_WORDS];
  logic [31:0] flash_q_r, lcd_q_r;

  // Frame and reply state.
  logic [7:0]  cmd_r, cmd_nxt;
  logic [31:0] fn_r, fn_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [AW:0] wp_r, wp_nxt;
  logic [31:0] echo_r, echo_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        settled_r, settled_nxt;
  logic [31:0] date_r;
  logic [23:0] time_r;

  // Block number modulo FLASH_BLOCKS, derived from the echo word through q_r and then blk_r.
  logic [7:0] q_r, blk_r;

  // Clearing pass.
  logic        clr_busy_r;
  logic [AW:0] clr_cnt_r;

  // Result stage waiting for memory data, then the output register.
  logic        p_valid_r;
  src_t        p_src_r;
  logic [31:0] p_word_r;
  logic        p_wvalid_r, p_last_r;
  logic [31:0] out_word_r;
  logic        out_valid_r, out_wvalid_r, out_last_r, out_cvalid_r;
  logic [2:0]  out_code_r;

  logic        accept;
  logic        fl_we, lcd_we;
  logic [AW-1:0]     fl_waddr, fl_raddr;
  logic [LCD_AW-1:0] lcd_waddr, lcd_raddr;
  logic [31:0] pop_word;
  src_t        pop_src;
  logic        pop_valid, pop_last;
  logic [7:0]  len;
  logic [STW-1:0] start;
  logic [15:0] w_less2;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !clr_busy_r && !p_valid_r && !out_valid_r;
  assign cfg_ready = 1'b1;

  // Reply length of the pending reply.
  always_comb begin
    unique case (kind_r)
      K_IDENT:    len = 8'd28;
      K_INFO_ST:  len = 8'd7;
      K_INFO_LCD: len = 8'd2;
      K_READ_ST:  len = 8'(2 + BW);
      K_READ_LCD: len = 8'(2 + LCD_WORDS);
      K_READ_CLK: len = 8'd3;
      default:    len = 8'd0;
    endcase
  end

  assign fl_raddr  = AW'(blk_r * BW) + AW'(idx_r - 8'd2);
  assign lcd_raddr = LCD_AW'(idx_r - 8'd2);

  // Word for a pop at the current reply index; stored data comes from the registered read in the next cycle.
  always_comb begin
    pop_word = 32'h0;
    pop_src  = SRC_CONST;
    unique case (kind_r)
      K_IDENT:    pop_word = ident_word(idx_r);
      K_INFO_ST:  pop_word = info_word(idx_r);
      K_INFO_LCD: pop_word = (idx_r == 8'd0) ? FN_LCD : LCD_INFO_WORD;
      K_READ_ST: begin
        if (idx_r == 8'd0) pop_word = FN_STORAGE;
        else if (idx_r == 8'd1) pop_word = echo_r;
        else pop_src = SRC_FLASH;
      end
      K_READ_LCD: begin
        if (idx_r == 8'd0) pop_word = FN_LCD;
        else if (idx_r == 8'd1) pop_word = echo_r;
        else pop_src = SRC_LCD;
      end
      K_READ_CLK: begin
        if (idx_r == 8'd0) pop_word = FN_CLOCK;
        else if (idx_r == 8'd1) pop_word = date_r;
        else pop_word = {8'h0, time_r};
      end
      default: pop_word = 32'h0;
    endcase
  end

  // Write start from the parameter word: block * BW + phase * (BLOCK_BYTES/16).
  // The block number sits byte swapped in the top half, the phase in bits 15:8.
  assign start = STW'({in_data[23:16], in_data[31:24]}) * STW'(BW)
               + STW'(in_data[15:8]) * STW'(PH);

  // Next state for pushes (request words) and pops (reply words).
  always_comb begin
    cmd_nxt     = cmd_r;
    fn_nxt      = fn_r;
    cnt_nxt     = cnt_r;
    wp_nxt      = wp_r;
    echo_nxt    = echo_r;
    kind_nxt    = kind_r;
    idx_nxt     = idx_r;
    status_nxt  = status_r;
    settled_nxt = settled_r;
    fl_we       = 1'b0;
    lcd_we      = 1'b0;
    w_less2     = cnt_r - 16'd2;
    fl_waddr    = wp_r[AW-1:0];
    lcd_waddr   = w_less2[LCD_AW-1:0];
    pop_valid   = 1'b0;
    pop_last    = 1'b0;
    if (accept && !in_op) begin
      if (in_frame_start) begin
        cmd_nxt  = in_command;
        fn_nxt   = 32'h0;
        cnt_nxt  = 16'h0;
        wp_nxt   = '0;
        echo_nxt = 32'h0;
      end
      kind_nxt    = K_NONE;
      idx_nxt     = 8'd0;
      settled_nxt = 1'b0;
      fl_waddr    = wp_nxt[AW-1:0];
      // Payload position within the frame, taken before the word count advances.
      w_less2     = cnt_nxt - 16'd2;
      lcd_waddr   = w_less2[LCD_AW-1:0];
      if (cnt_nxt == 16'd0) begin
        fn_nxt = in_data;
      end else if (cnt_nxt == 16'd1) begin
        echo_nxt = in_data;
        wp_nxt   = (start < STW'(FW)) ? (AW+1)'(start) : (AW+1)'(FW);
      end else if (cmd_nxt == CMD_WRITE) begin
        if (fn_nxt == FN_STORAGE) begin
          if (wp_nxt < (AW+1)'(FW)) begin
            fl_we  = 1'b1;
            wp_nxt = wp_nxt + 1'b1;
          end
        end else if (fn_nxt == FN_LCD) begin
          lcd_we = (w_less2 < 16'(LCD_WORDS));
        end
      end
      if (cnt_nxt != 16'hffff) cnt_nxt = cnt_nxt + 16'd1;
      if (in_frame_end) begin
        settled_nxt = 1'b1;
        status_nxt  = RC_BAD_CMD;
        unique case (cmd_nxt)
          CMD_IDENT: begin
            status_nxt = RC_STATUS;
            kind_nxt   = K_IDENT;
          end
          CMD_INFO: begin
            if (fn_nxt == FN_STORAGE) begin
              status_nxt = RC_DATA;
              kind_nxt   = K_INFO_ST;
            end else if (fn_nxt == FN_LCD) begin
              if (echo_nxt != 32'h0) status_nxt = RC_BAD_CMD;
              else begin
                status_nxt = RC_DATA;
                kind_nxt   = K_INFO_LCD;
              end
            end else status_nxt = RC_BAD_FN;
          end
          CMD_READ: begin
            if (fn_nxt == FN_STORAGE) begin
              status_nxt = RC_DATA;
              kind_nxt   = K_READ_ST;
            end else if (fn_nxt == FN_LCD) begin
              status_nxt = RC_DATA;
              kind_nxt   = K_READ_LCD;
            end else if (fn_nxt == FN_CLOCK) begin
              if (echo_nxt != 32'h0) status_nxt = RC_RESEND;
              else begin
                status_nxt = RC_DATA;
                kind_nxt   = K_READ_CLK;
              end
            end else status_nxt = RC_BAD_FN;
          end
          CMD_WRITE: begin
            if (fn_nxt == FN_STORAGE || fn_nxt == FN_LCD) status_nxt = RC_OK;
            else if (fn_nxt == FN_CLOCK)
              status_nxt = (echo_nxt != 32'h0 || cnt_nxt != 16'd4) ? RC_RESEND : RC_OK;
            else status_nxt = RC_BAD_FN;
          end
          CMD_SYNC: status_nxt = RC_OK;
          CMD_SET:  status_nxt = (fn_nxt == FN_CLOCK) ? RC_OK : RC_BAD_FN;
          default:  status_nxt = RC_BAD_CMD;
        endcase
      end
    end else if (accept && kind_r != K_NONE) begin
      if (idx_r < len) begin
        pop_valid = 1'b1;
        pop_last  = (idx_r + 8'd1 == len);
        idx_nxt   = idx_r + 8'd1;
      end
      if (pop_last || !pop_valid) begin
        kind_nxt = K_NONE;
        idx_nxt  = 8'd0;
      end
    end
  end

  // Flash store: clearing pass after reset, payload writes, registered read.
  always_ff @(posedge clk) begin
    if (clr_busy_r) flash_mem[clr_cnt_r[AW-1:0]] <= 32'h0;
    else if (fl_we) flash_mem[fl_waddr] <= in_data;
    flash_q_r <= flash_mem[fl_raddr];
  end

  // LCD store, cleared in the first cycles of the same pass.
  always_ff @(posedge clk) begin
    if (clr_busy_r && clr_cnt_r < (AW+1)'(LCD_WORDS)) lcd_mem[clr_cnt_r[LCD_AW-1:0]] <= 32'h0;
    else if (lcd_we) lcd_mem[lcd_waddr] <= in_data;
    lcd_q_r <= lcd_mem[lcd_raddr];
  end

  // Block number modulo FLASH_BLOCKS by a reciprocal multiply; q is exact for 8-bit values.
  always_ff @(posedge clk) begin
    q_r   <= 8'((24'(echo_r[31:24]) * 24'(RECIP)) >> 16);
    blk_r <= echo_r[31:24] - 8'(16'(q_r) * 16'(FLASH_BLOCKS));
  end

  // Payload side of the result stage and output register.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_src_r    <= pop_src;
      p_word_r   <= pop_word;
      p_wvalid_r <= pop_valid;
      p_last_r   <= pop_last;
    end
    if (p_valid_r) begin
      if (!p_wvalid_r) out_word_r <= 32'h0;
      else begin
        case (p_src_r)
          SRC_FLASH: out_word_r <= flash_q_r;
          SRC_LCD:   out_word_r <= lcd_q_r;
          default:   out_word_r <= p_word_r;
        endcase
      end
      out_wvalid_r <= p_wvalid_r;
      out_last_r   <= p_last_r;
      out_cvalid_r <= settled_r;
      out_code_r   <= settled_r ? status_r : RC_STATUS;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= 8'h0;
      fn_r        <= 32'h0;
      cnt_r       <= 16'h0;
      wp_r        <= '0;
      echo_r      <= 32'h0;
      kind_r      <= K_NONE;
      idx_r       <= 8'd0;
      status_r    <= RC_STATUS;
      settled_r   <= 1'b0;
      date_r      <= 32'h0;
      time_r      <= 24'h0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmd_r     <= cmd_nxt;
      fn_r      <= fn_nxt;
      cnt_r     <= cnt_nxt;
      wp_r      <= wp_nxt;
      echo_r    <= echo_nxt;
      kind_r    <= kind_nxt;
      idx_r     <= idx_nxt;
      status_r  <= status_nxt;
      settled_r <= settled_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DATE: date_r <= cfg_data;
          CFG_TIME: time_r <= cfg_data[23:0];
          default:  date_r <= date_r;
        endcase
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(FW - 1)) clr_busy_r <= 1'b0;
      end
      p_valid_r <= accept;
      if (p_valid_r) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reply_word = out_word_r;
  assign out_word_valid = out_wvalid_r;
  assign out_reply_last = out_last_r;
  assign out_reply_code = out_code_r;
  assign out_code_valid = out_cvalid_r;

  // Every accepted beat reaches the result stage in the next cycle.
  a_accept_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> p_valid_r) else $error("accepted beat did not reach result stage");

  // A last flag only comes with a valid word.
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_last |-> out_word_valid) else $error("last without word");

  // Without a settled frame the reply code reads as zero.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_code_valid |-> out_reply_code == RC_STATUS)
    else $error("code without frame end");

  // No beat is taken while the clearing pass runs.
  a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready && !out_valid) else $error("beat during clearing pass");

endmodule

### verif/tb_memory_card_command_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Memory card command responder testbench
// Drives request frames and reply pops through the valid/ready input channel,
// predicts every result beat with a behavioral copy of the card and compares
// each result beat field by field. It also sets the clock registers after reset
// and again after each 300 or more input beats in the random part.
// ----------------------------------------------------------------------------
module tb_memory_card_command_responder;
  import mccr_pkg::*;

  localparam int FLASH_WORDS = 32768;
  localparam int BLOCK_WORDS = 128;
  localparam int WATCHDOG_LIMIT = 120000;
  localparam int TARGET_ITEMS = 1800;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum int {
    RK_NONE, RK_IDENT, RK_INFO_ST, RK_INFO_LCD, RK_READ_ST, RK_READ_LCD, RK_READ_CLK
  } reply_kind_t;

  typedef struct {
    logic [31:0] word;
    logic        wvalid;
    logic        last;
    logic [2:0]  code;
    logic        cvalid;
  } reply_beat_t;

  // The scoreboard holds its own copy of the card and the queue of beats that
  // the block still owes.
  class card_scoreboard;
    logic [31:0] flash[FLASH_WORDS];
    logic [31:0] lcd[LCD_WORDS];
    logic [31:0] ident_tab[28];
    logic [31:0] info_tab[7];
    logic [7:0]  cur_cmd;
    logic [31:0] cur_fn;
    int          word_cnt;
    int          wr_ptr;
    logic [31:0] echo;
    reply_kind_t kind;
    int          ridx;
    logic [2:0]  status;
    bit          settled;
    logic [31:0] clk_date;
    logic [23:0] clk_time;
    reply_beat_t pending[$];
    int          errors;

    function new();
      foreach (flash[i]) flash[i] = '0;
      foreach (lcd[i]) lcd[i] = '0;
      ident_tab = '{32'h0e000000, 32'h403f7e7e, 32'h00100500, 32'h00410f00, 32'h695600ff,
                    32'h6c617573, 32'h6d654d20, 32'h2079726f, 32'h20202020, 32'h20202020,
                    32'h20202020, 32'h20202020, 32'h646f7250, 32'h64656375, 32'h20794220,
                    32'h5520726f, 32'h7265646e, 32'h63694c20, 32'h65736e65, 32'h6f724620,
                    32'h4553206d, 32'h45204147, 32'h5245544e, 32'h53495250, 32'h4c2c5345,
                    32'h202e4454, 32'h20202020, 32'h0082007c};
      info_tab = '{FN_STORAGE, 32'h000000ff, 32'h00fe00ff, 32'h00fd0001, 32'h0000000d,
                   32'h001f00c8, 32'h00000000};
      cur_cmd = '0; cur_fn = '0; word_cnt = 0; wr_ptr = 0; echo = '0;
      kind = RK_NONE; ridx = 0; status = RC_STATUS; settled = 0;
      clk_date = '0; clk_time = '0; errors = 0;
    endfunction

    function logic [31:0] swap32(logic [31:0] a);
      return {a[7:0], a[15:8], a[23:16], a[31:24]};
    endfunction

    function int reply_len(reply_kind_t k);
      case (k)
        RK_IDENT:    return 28;
        RK_INFO_ST:  return 7;
        RK_INFO_LCD: return 2;
        RK_READ_ST:  return 2 + BLOCK_WORDS;
        RK_READ_LCD: return 2 + LCD_WORDS;
        RK_READ_CLK: return 3;
        default:     return 0;
      endcase
    endfunction

    function logic [31:0] reply_word_at(reply_kind_t k, int i);
      logic [31:0] sw;
      case (k)
        RK_IDENT:    return ident_tab[i];
        RK_INFO_ST:  return info_tab[i];
        RK_INFO_LCD: return (i == 0) ? FN_LCD : LCD_INFO_WORD;
        RK_READ_ST: begin
          if (i == 0) return FN_STORAGE;
          if (i == 1) return echo;
          sw = swap32(echo);
          return flash[sw[7:0] * BLOCK_WORDS + (i - 2)];
        end
        RK_READ_LCD: begin
          if (i == 0) return FN_LCD;
          if (i == 1) return echo;
          return lcd[i - 2];
        end
        RK_READ_CLK: begin
          if (i == 0) return FN_CLOCK;
          if (i == 1) return clk_date;
          return {8'h00, clk_time};
        end
        default: return '0;
      endcase
    endfunction

    // Decide the reply code and reply sequence once the frame end arrives.
    function void settle_frame();
      logic [2:0] code;
      reply_kind_t k;
      code = RC_BAD_CMD;
      k = RK_NONE;
      case (cur_cmd)
        CMD_IDENT: begin
          code = RC_STATUS; k = RK_IDENT;
        end
        CMD_INFO: begin
          if (cur_fn == FN_STORAGE) begin
            code = RC_DATA; k = RK_INFO_ST;
          end else if (cur_fn == FN_LCD) begin
            if (echo != 0) code = RC_BAD_CMD;
            else begin
              code = RC_DATA; k = RK_INFO_LCD;
            end
          end else code = RC_BAD_FN;
        end
        CMD_READ: begin
          if (cur_fn == FN_STORAGE) begin
            code = RC_DATA; k = RK_READ_ST;
          end else if (cur_fn == FN_LCD) begin
            code = RC_DATA; k = RK_READ_LCD;
          end else if (cur_fn == FN_CLOCK) begin
            if (echo != 0) code = RC_RESEND;
            else begin
              code = RC_DATA; k = RK_READ_CLK;
            end
          end else code = RC_BAD_FN;
        end
        CMD_WRITE: begin
          if (cur_fn == FN_STORAGE || cur_fn == FN_LCD) code = RC_OK;
          else if (cur_fn == FN_CLOCK) code = (echo != 0 || word_cnt != 4) ? RC_RESEND : RC_OK;
          else code = RC_BAD_FN;
        end
        CMD_SYNC: code = RC_OK;
        CMD_SET:  code = (cur_fn == FN_CLOCK) ? RC_OK : RC_BAD_FN;
        default:  code = RC_BAD_CMD;
      endcase
      status = code;
      kind = k;
      ridx = 0;
      settled = 1;
    endfunction

    function void set_cfg(logic [0:0] index, logic [31:0] value);
      if (index == CFG_DATE) clk_date = value;
      else clk_time = value[23:0];
    endfunction

    // One accepted input beat: update the card copy and queue the result beat.
    function void note_input(logic op, logic fs, logic [7:0] cmd, logic [31:0] data,
                             logic fe);
      reply_beat_t b;
      logic [31:0] sw;
      int start;
      int len;
      b = '{word: '0, wvalid: 1'b0, last: 1'b0, code: '0, cvalid: 1'b0};
      if (op == OP_PUSH) begin
        if (fs) begin
          cur_cmd = cmd; cur_fn = '0; word_cnt = 0; wr_ptr = 0; echo = '0;
        end
        kind = RK_NONE;
        ridx = 0;
        settled = 0;
        if (word_cnt == 0) cur_fn = data;
        else if (word_cnt == 1) begin
          echo = data;
          sw = swap32(data);
          start = int'(sw[15:0]) * BLOCK_WORDS + int'(sw[23:16]) * (BLOCK_WORDS / 4);
          wr_ptr = (start < FLASH_WORDS) ? start : FLASH_WORDS;
        end else if (cur_cmd == CMD_WRITE) begin
          if (cur_fn == FN_STORAGE) begin
            if (wr_ptr < FLASH_WORDS) begin
              flash[wr_ptr] = data;
              wr_ptr++;
            end
          end else if (cur_fn == FN_LCD) begin
            if (word_cnt - 2 < LCD_WORDS) lcd[word_cnt - 2] = data;
          end
        end
        if (word_cnt < 16'hffff) word_cnt++;
        if (fe) settle_frame();
      end else if (kind != RK_NONE) begin
        len = reply_len(kind);
        if (ridx < len) begin
          b.word = reply_word_at(kind, ridx);
          b.wvalid = 1'b1;
          b.last = (ridx + 1 == len);
          ridx = (ridx + 1) & 8'hff;
        end
        if (b.last || !b.wvalid) begin
          kind = RK_NONE;
          ridx = 0;
        end
      end
      b.code = settled ? status : '0;
      b.cvalid = settled;
      pending.push_back(b);
    endfunction

    function void check_result(reply_beat_t got);
      reply_beat_t exp_b;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, word %h", $time, got.word);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (got.word !== exp_b.word) begin
        $display("%0t: reply_word expected %h actual %h", $time, exp_b.word, got.word);
        errors++;
      end
      if (got.wvalid !== exp_b.wvalid) begin
        $display("%0t: word_valid expected %b actual %b", $time, exp_b.wvalid, got.wvalid);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $display("%0t: reply_last expected %b actual %b", $time, exp_b.last, got.last);
        errors++;
      end
      if (got.code !== exp_b.code) begin
        $display("%0t: reply_code expected %0d actual %0d", $time, exp_b.code, got.code);
        errors++;
      end
      if (got.cvalid !== exp_b.cvalid) begin
        $display("%0t: code_valid expected %b actual %b", $time, exp_b.cvalid, got.cvalid);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic        in_frame_start = 1'b0;
  logic [7:0]  in_command = '0;
  logic [31:0] in_data = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_reply_word;
  logic        out_word_valid;
  logic        out_reply_last;
  logic [2:0]  out_reply_code;
  logic        out_code_valid;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_DATE;
  logic [31:0] cfg_data = '0;

  card_scoreboard sb = new();
  int items_done = 0;
  int snd_idle = 11;
  int rcv_idle = 77;
  int quiet_cycles = 0;

  memory_card_command_responder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_frame_start (in_frame_start),
    .in_command     (in_command),
    .in_data        (in_data),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reply_word (out_reply_word),
    .out_word_valid (out_word_valid),
    .out_reply_last (out_reply_last),
    .out_reply_code (out_reply_code),
    .out_code_valid (out_code_valid),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check the beat that was accepted at this edge, then choose
  // whether to stall on the next one. Values read here are the pre-edge ones.
  always @(posedge clk) begin
    reply_beat_t got;
    if (out_valid && out_ready) begin
      got = '{word: out_reply_word, wvalid: out_word_valid, last: out_reply_last,
              code: out_reply_code, cvalid: out_code_valid};
      sb.check_result(got);
    end
    if (rst_n) out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Watchdog: any handshake on any channel counts as progress. The limit
  // covers the flash clearing pass that follows reset.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one input beat. An idle gap, if drawn, comes before the beat so that
  // valid is never dropped and raised within one time step.
  task automatic send_beat(logic op, logic fs, logic [7:0] cmd, logic [31:0] data,
                           logic fe);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_frame_start <= fs;
    in_command <= cmd;
    in_data <= data;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, fs, cmd, data, fe);
    items_done++;
  endtask

  task automatic push_word(logic fs, logic [7:0] cmd, logic [31:0] data, logic fe);
    send_beat(OP_PUSH, fs, cmd, data, fe);
  endtask

  // Pops carry random content in the unused fields.
  task automatic pop_words(int n);
    repeat (n) send_beat(OP_POP, 1'($urandom_range(1)), 8'($urandom_range(255)), $urandom,
                         1'($urandom_range(1)));
  endtask

  // Block parameter word: the block number travels byte swapped in the top half, the phase in bits 15:8.
  function automatic logic [31:0] block_param(logic [15:0] blk, logic [7:0] phase);
    return {blk[7:0], blk[15:8], phase, 8'h00};
  endfunction

  // Push a whole frame: function word, optional parameter and payload words.
  task automatic send_frame(logic [7:0] cmd, logic [31:0] fn, bit has_param,
                            logic [31:0] param, int payload);
    int total;
    int k;
    total = 1 + (has_param ? 1 : 0) + payload;
    push_word(1'b1, cmd, fn, total == 1);
    if (has_param) push_word(1'b0, 8'($urandom_range(255)), param, total == 2);
    for (k = 0; k < payload; k++)
      push_word(1'b0, 8'($urandom_range(255)), $urandom, k == payload - 1);
  endtask

  // Registers change only once the block has drained every owed beat.
  task automatic write_reg(logic [0:0] index, logic [31:0] value);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_cfg(index, value);
  endtask

  task automatic random_request();
    int sel;
    logic [31:0] fn;
    logic [15:0] blk;
    sel = $urandom_range(15);
    blk = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(7));
    case (sel)
      0: begin
        send_frame(CMD_IDENT, $urandom, 1'($urandom_range(1)), $urandom, 0);
        pop_words($urandom_range(30, 20));
      end
      1: begin
        send_frame(CMD_INFO, FN_STORAGE, 1'b1, $urandom, 0);
        pop_words($urandom_range(9, 5));
      end
      2: begin
        send_frame(CMD_INFO, FN_LCD, 1'b1, ($urandom_range(3) == 0) ? $urandom : 32'h0, 0);
        pop_words($urandom_range(3, 1));
      end
      3, 4: begin
        send_frame(CMD_READ, FN_STORAGE, 1'b1, block_param(blk, 8'($urandom_range(3))), 0);
        pop_words(($urandom_range(3) == 0) ? $urandom_range(131, 100) : $urandom_range(12, 2));
      end
      5: begin
        send_frame(CMD_READ, FN_LCD, 1'b1, $urandom, 0);
        pop_words($urandom_range(51, 10));
      end
      6: begin
        send_frame(CMD_READ, FN_CLOCK, $urandom_range(3) != 0,
                   ($urandom_range(3) == 0) ? $urandom : 32'h0, 0);
        pop_words($urandom_range(4, 1));
      end
      7, 8, 9: begin
        send_frame(CMD_WRITE, FN_STORAGE, 1'b1,
                   block_param(($urandom_range(15) == 0) ? 16'hffff : blk,
                               8'($urandom_range(3))),
                   $urandom_range(12, 1));
        pop_words(1);
      end
      10: begin
        send_frame(CMD_WRITE, FN_LCD, 1'b1, $urandom,
                   ($urandom_range(3) == 0) ? $urandom_range(52, 45) : $urandom_range(8));
        pop_words(1);
      end
      11: begin
        send_frame(CMD_WRITE, FN_CLOCK, 1'b1, ($urandom_range(3) == 0) ? $urandom : 32'h0,
                   ($urandom_range(3) == 0) ? $urandom_range(4) : 2);
        pop_words(1);
      end
      12: begin
        send_frame(CMD_SYNC, $urandom, 1'($urandom_range(1)), $urandom, $urandom_range(2));
        pop_words(1);
      end
      13: begin
        fn = ($urandom_range(1) == 0) ? FN_CLOCK : $urandom;
        send_frame(CMD_SET, fn, 1'b1, $urandom, $urandom_range(2));
        pop_words(1);
      end
      14: begin
        send_frame(8'($urandom_range(255)), $urandom, 1'($urandom_range(1)), $urandom,
                   $urandom_range(2));
        pop_words($urandom_range(3));
      end
      default: begin
        // Noise: unframed pushes and pops with random fields.
        repeat ($urandom_range(4, 1))
          send_beat(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                    $urandom, 1'($urandom_range(1)));
      end
    endcase
  endtask

  initial begin
    int next_cfg;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_DATE, 32'hffff_ffff);
    write_reg(CFG_TIME, 32'h00ff_ffff);

    // Directed part.
    pop_words(1);                                         // pop with nothing pending
    send_frame(CMD_IDENT, 32'h0, 0, 32'h0, 0);
    pop_words(3);
    push_word(1'b0, 8'h00, 32'h1234_5678, 1'b1);          // push without frame start
    send_frame(CMD_INFO, FN_LCD, 1, 32'h0000_0001, 0);    // nonzero LCD info parameter
    send_frame(CMD_READ, FN_CLOCK, 0, 32'h0, 0);          // missing parameter word
    pop_words(4);
    send_frame(CMD_WRITE, FN_CLOCK, 1, 32'h0100_0000, 2); // clock write resend
    send_frame(CMD_WRITE, FN_STORAGE, 1, block_param(16'hffff, 8'hff), 2); // past flash end
    send_frame(CMD_WRITE, FN_STORAGE, 1, block_param(16'h00ff, 8'h03), 2);
    send_frame(8'hff, 32'hffff_ffff, 0, 32'h0, 0);        // unknown command
    send_frame(CMD_SET, 32'h0, 0, 32'h0, 0);              // unknown function
    pop_words(2);

    // Random part, in three idling phases, with register changes after each 300 or more input beats.
    next_cfg = items_done + 300;
    while (items_done < TARGET_ITEMS) begin
      if (items_done < TARGET_ITEMS / 3) begin
        snd_idle = 11; rcv_idle = 77;
      end else if (items_done < 2 * TARGET_ITEMS / 3) begin
        snd_idle = 77; rcv_idle = 11;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      if (items_done >= next_cfg) begin
        case ($urandom_range(2))
          0: begin
            write_reg(CFG_DATE, 32'h0);
            write_reg(CFG_TIME, 32'h0);
          end
          default: begin
            write_reg(CFG_DATE, $urandom);
            write_reg(CFG_TIME, $urandom);
          end
        endcase
        next_cfg = items_done + 300;
      end
      random_request();
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### memory_card_command_responder.f
rtl/core/mccr_pkg.sv
rtl/core/memory_card_command_responder.sv
verif/tb_memory_card_command_responder.sv
